### hw/rtl/signed_distance_field_pixel_assert.svh
// assertion macros shared by the sdfp modules
// they expect clk and arst_n in the scope where they are used
`ifndef SIGNED_DISTANCE_FIELD_PIXEL_ASSERT_SVH
`define SIGNED_DISTANCE_FIELD_PIXEL_ASSERT_SVH

// same-cycle implication
`define SDFP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SDFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/sdfp_pkg.sv
package sdfp_pkg;

	localparam int MAX_SIDE_DEF = 64;
	localparam int REACH_DEF    = 12;

	localparam int CFG_W   = 7;
	localparam int POS_IN_W = 6;
	localparam int CODE_W  = 8;
	localparam int ROOT_W  = 7;
	localparam int SQ_W    = 2 * ROOT_W;
	localparam int BIT_W   = $clog2(ROOT_W);
	localparam int LEVEL_W = 16;

	localparam logic [CFG_W-1:0]   IMAGE_SIDE_RST = 7'd64;
	localparam logic [CODE_W-1:0]  CODE_MID       = 8'd128;
	localparam logic [LEVEL_W-1:0] LEVEL_SQ       = 16'd65025;

	// register indexes
	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	// item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic accept;
		logic clear;
		logic rd_centre;
		logic scan_issue;
		logic code_zero;
		logic start_root;
		logic square;
		logic test;
		logic make_code;
		logic load_out;
	} sdfp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic in_range;
		logic scan_last;
		logic root_last;
		logic out_free;
	} sdfp_status_t;

endpackage

### hw/rtl/sdfp_ctrl.sv
module sdfp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   kind,
	input  sdfp_pkg::sdfp_status_t status,
	output sdfp_pkg::sdfp_cmd_t    cmd
);
	import sdfp_pkg::*;

	`include "signed_distance_field_pixel_assert.svh"

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CENTRE,
		ST_SCAN,
		ST_DRAIN,
		ST_TARGET,
		ST_SQUARE,
		ST_TEST,
		ST_FINISH,
		ST_OUT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clear_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid && kind == KIND_QUERY) state_q <= ST_CENTRE;
				end
				ST_CENTRE: begin
					state_q <= status.in_range ? ST_SCAN : ST_OUT;
				end
				ST_SCAN: begin
					if (status.scan_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN:  state_q <= ST_TARGET;
				ST_TARGET: state_q <= ST_SQUARE;
				ST_SQUARE: state_q <= ST_TEST;
				ST_TEST: begin
					state_q <= status.root_last ? ST_FINISH : ST_SQUARE;
				end
				ST_FINISH: state_q <= ST_OUT;
				ST_OUT: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.accept = in_valid && in_ready;
		unique case (state_q)
			ST_CLEAR:  cmd.clear = 1'b1;
			ST_CENTRE: begin
				cmd.rd_centre = status.in_range;
				cmd.code_zero = !status.in_range;
			end
			ST_SCAN:   cmd.scan_issue = 1'b1;
			ST_TARGET: cmd.start_root = 1'b1;
			ST_SQUARE: cmd.square = 1'b1;
			ST_TEST:   cmd.test = 1'b1;
			ST_FINISH: cmd.make_code = 1'b1;
			ST_OUT:    cmd.load_out = status.out_free;
			default: begin
			end
		endcase
	end

	`SDFP_ASSERT_IMP(a_load_needs_free_slot, cmd.load_out, status.out_free, "result overwritten")
	`SDFP_ASSERT_NEXT(a_query_goes_busy, cmd.accept && kind == KIND_QUERY, !in_ready, "query not held busy")

endmodule

### hw/rtl/sdfp_datapath.sv
module sdfp_datapath #(
	parameter int MAX_SIDE = sdfp_pkg::MAX_SIDE_DEF,
	parameter int REACH    = sdfp_pkg::REACH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sdfp_pkg::sdfp_cmd_t           cmd,
	output sdfp_pkg::sdfp_status_t        status,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [sdfp_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          kind,
	input  logic [sdfp_pkg::POS_IN_W-1:0] col,
	input  logic [sdfp_pkg::POS_IN_W-1:0] row,
	input  logic                          pixel_on,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sdfp_pkg::CODE_W-1:0]   distance_code
);
	import sdfp_pkg::*;

	`include "signed_distance_field_pixel_assert.svh"

	localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
	localparam int WIDE_W  = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;
	localparam int POS_W   = (WIDE_W > POS_IN_W) ? WIDE_W + 1 : POS_IN_W + 1;
	localparam int COORD_W = POS_W + 1;
	localparam int N_MAX   = 2 * REACH * REACH;
	localparam int N_W     = $clog2(N_MAX + 1);
	localparam int OFF_W   = $clog2(REACH) + 2;
	localparam int SCALE   = 8 * REACH * REACH;
	localparam int TGT_W   = LEVEL_W + N_W;
	localparam int PROD_W  = SQ_W + $clog2(SCALE + 1);
	localparam int CMP_W   = (TGT_W > PROD_W) ? TGT_W : PROD_W;

	localparam logic [N_W-1:0]          BEST_INIT = N_W'(N_MAX);
	localparam logic signed [OFF_W-1:0] OFF_LO    = OFF_W'(1 - REACH);
	localparam logic signed [OFF_W-1:0] OFF_HI    = OFF_W'(REACH - 1);
	localparam logic [ADDR_W-1:0]       ADDR_LAST = ADDR_W'(DEPTH - 1);

	logic [0:0] mem [DEPTH];

	logic [CFG_W-1:0]    width_q, height_q;
	logic [POS_W-1:0]    w_eff, h_eff;
	logic [ADDR_W-1:0]   clear_addr_q;
	logic [POS_IN_W-1:0] col_q, row_q;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr, rd_addr, wr_addr, centre_addr, scan_addr;
	logic                mem_wdata;
	logic                wr_ok;

	logic signed [OFF_W-1:0]   di_q, dj_q;
	logic        [COORD_W-1:0] y_pos, x_pos;
	logic                      y_ok, x_ok;
	logic signed [N_W:0]       di_x, dj_x;
	logic        [N_W-1:0]     n_calc;

	logic                 rd_bit_s1, valid_s1, rd_centre_s1;
	logic [N_W-1:0]       n_s1;
	logic                 centre_q;
	logic [N_W-1:0]       best_q;

	logic [TGT_W-1:0]     target_q;
	logic [ROOT_W-1:0]    fl_q, trial;
	logic [BIT_W-1:0]     bit_q;
	logic                 eq_q;
	logic [SQ_W-1:0]      sq_q;
	logic [CMP_W-1:0]     prod;

	logic [CODE_W-1:0]    code_q, distance_code_q;
	logic                 out_valid_q;

	// sizes above MAX_SIDE act as MAX_SIDE
	assign w_eff = (POS_W'(width_q) > POS_W'(MAX_SIDE)) ? POS_W'(MAX_SIDE) : POS_W'(width_q);
	assign h_eff = (POS_W'(height_q) > POS_W'(MAX_SIDE)) ? POS_W'(MAX_SIDE) : POS_W'(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMAGE_SIDE_RST;
			height_q <= IMAGE_SIDE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// pixel writes and the clearing pass share the write port
	assign wr_ok = cmd.accept && kind == KIND_WRITE
		&& POS_W'(col) < POS_W'(MAX_SIDE) && POS_W'(row) < POS_W'(MAX_SIDE);
	assign wr_addr = ADDR_W'(row) * ADDR_W'(MAX_SIDE) + ADDR_W'(col);

	assign mem_we    = cmd.clear || wr_ok;
	assign mem_waddr = cmd.clear ? clear_addr_q : wr_addr;
	assign mem_wdata = cmd.clear ? 1'b0 : pixel_on;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_addr_q <= '0;
		end else if (cmd.clear) begin
			clear_addr_q <= clear_addr_q + ADDR_W'(1);
		end
	end

	// window position of the current read
	assign y_pos = COORD_W'(row_q) + COORD_W'(di_q);
	assign x_pos = COORD_W'(col_q) + COORD_W'(dj_q);
	assign y_ok  = !y_pos[COORD_W-1] && (y_pos[POS_W-1:0] < h_eff);
	assign x_ok  = !x_pos[COORD_W-1] && (x_pos[POS_W-1:0] < w_eff);

	assign scan_addr   = ADDR_W'(y_pos) * ADDR_W'(MAX_SIDE) + ADDR_W'(x_pos);
	assign centre_addr = ADDR_W'(row_q) * ADDR_W'(MAX_SIDE) + ADDR_W'(col_q);
	assign rd_addr     = cmd.rd_centre ? centre_addr : scan_addr;

	assign di_x   = (N_W + 1)'(di_q);
	assign dj_x   = (N_W + 1)'(dj_q);
	assign n_calc = N_W'(di_x * di_x + dj_x * dj_x);

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_bit_s1 <= mem[rd_addr][0];
		n_s1      <= n_calc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			rd_centre_s1 <= 1'b0;
		end else begin
			valid_s1     <= cmd.scan_issue && y_ok && x_ok;
			rd_centre_s1 <= cmd.rd_centre;
		end
	end

	// query position, window counters and running minimum
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			col_q  <= col;
			row_q  <= row;
			di_q   <= OFF_LO;
			dj_q   <= OFF_LO;
			best_q <= BEST_INIT;
		end else begin
			if (cmd.scan_issue) begin
				if (dj_q == OFF_HI) begin
					dj_q <= OFF_LO;
					di_q <= di_q + OFF_W'(1);
				end else begin
					dj_q <= dj_q + OFF_W'(1);
				end
			end
			if (valid_s1 && rd_bit_s1 != centre_q && n_s1 < best_q) best_q <= n_s1;
		end
		if (rd_centre_s1) centre_q <= rd_bit_s1;
	end

	// square root one bit at a time, each bit a square step, then a scale and compare step
	assign trial = fl_q | (ROOT_W'(1) << bit_q);
	assign prod  = CMP_W'(sq_q) * CMP_W'(SCALE);

	always_ff @(posedge clk) begin
		if (cmd.start_root) begin
			target_q <= TGT_W'(LEVEL_SQ) * TGT_W'(best_q);
			fl_q     <= '0;
			bit_q    <= BIT_W'(ROOT_W - 1);
			eq_q     <= (best_q == '0);
		end
		if (cmd.square) sq_q <= SQ_W'(trial) * SQ_W'(trial);
		if (cmd.test) begin
			if (prod <= CMP_W'(target_q)) begin
				fl_q <= trial;
				eq_q <= (prod == CMP_W'(target_q));
			end
			bit_q <= bit_q - BIT_W'(1);
		end
		// inside adds the distance rounded down to the middle, outside subtracts it rounded up
		if (cmd.code_zero) begin
			code_q <= '0;
		end else if (cmd.make_code) begin
			code_q <= centre_q ? CODE_MID + CODE_W'(fl_q)
				: CODE_MID - CODE_W'(fl_q) - CODE_W'(!eq_q);
		end
		if (cmd.load_out) distance_code_q <= code_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign distance_code = distance_code_q;

	assign status.clear_last = (clear_addr_q == ADDR_LAST);
	assign status.in_range   = (POS_W'(col_q) < w_eff) && (POS_W'(row_q) < h_eff);
	assign status.scan_last  = (di_q == OFF_HI) && (dj_q == OFF_HI);
	assign status.root_last  = (bit_q == '0);
	assign status.out_free   = !out_valid_q || out_ready;

	`SDFP_ASSERT_IMP(a_best_bounded, cmd.start_root, best_q <= BEST_INIT, "minimum above window bound")
	`SDFP_ASSERT_IMP(a_hit_from_scan, valid_s1, $past(cmd.scan_issue), "window beat without read")
	`SDFP_ASSERT_NEXT(a_inside_upper, cmd.make_code && centre_q, code_q >= CODE_MID, "inside code low")

endmodule

### hw/rtl/signed_distance_field_pixel.sv
// Signed distance field of a stored binary image, one pixel per beat. A write beat
// (kind 0) stores pixel_on at (col,row); while idle, beats can follow every cycle.
// A query beat (kind 1) scans the (2*REACH-1)^2 window around (col,row) one pixel a
// cycle through the single read port of the bit memory, then takes a 7-bit square
// root one bit at a time, each bit a square and then a scaled compare; a query
// outside image_width x image_height answers 0. After reset the image memory is
// cleared one pixel a cycle, all MAX_SIDE*MAX_SIDE pixels (4096 by default), before
// the first beat is taken; configuration writes are taken at any time. The result
// sits in an output register, so the next beat is taken while it waits.
module signed_distance_field_pixel #(
	parameter int MAX_SIDE = sdfp_pkg::MAX_SIDE_DEF,
	parameter int REACH    = sdfp_pkg::REACH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [sdfp_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [sdfp_pkg::POS_IN_W-1:0] col,
	input  logic [sdfp_pkg::POS_IN_W-1:0] row,
	input  logic                          pixel_on,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sdfp_pkg::CODE_W-1:0]   distance_code
);
	import sdfp_pkg::*;

	sdfp_cmd_t    cmd;
	sdfp_status_t status;

	sdfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.status   (status),
		.cmd      (cmd)
	);

	sdfp_datapath #(
		.MAX_SIDE (MAX_SIDE),
		.REACH    (REACH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.kind          (kind),
		.col           (col),
		.row           (row),
		.pixel_on      (pixel_on),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.distance_code (distance_code)
	);

endmodule
